>>> sv/eotd_pkg.sv
// Shared types and constants for the elevator order table dispatch core.
// Order, mode, direction and pass codes, plus controller/datapath command and status.
package eotd_pkg;

  localparam int FLOORS_DEF = 4;

  localparam logic [2:0] CODE_NONE   = 3'd0;
  localparam logic [2:0] CODE_UP     = 3'd1;
  localparam logic [2:0] CODE_DOWN   = 3'd2;
  localparam logic [2:0] CODE_BOTH   = 3'd3;
  localparam logic [2:0] CODE_INSIDE = 3'd4;

  localparam logic [1:0] MODE_SAMPLE    = 2'd0;
  localparam logic [1:0] MODE_CLR_FLOOR = 2'd1;
  localparam logic [1:0] MODE_CLR_ALL   = 2'd2;
  localparam logic [1:0] MODE_QUERY     = 2'd3;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [1:0] PASS_MATCH = 2'd0;
  localparam logic [1:0] PASS_ANY   = 2'd1;
  localparam logic [1:0] PASS_BACK  = 2'd2;

  typedef struct packed {
    logic capture;
    logic rd_cur;
    logic exec;
    logic rd_scan;
    logic scan_chk;
    logic load_out;
  } eotd_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic hit;
    logic exhausted;
    logic out_free;
  } eotd_sts_t;

endpackage

>>> sv/eotd_ctrl.sv
// Sequencer for the elevator order table dispatch core.
// Depends on eotd_pkg for the command and status structs.
module eotd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  eotd_pkg::eotd_sts_t sts,
  output eotd_pkg::eotd_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_CUR   = 6'b000100,
    S_SRD   = 6'b001000,
    S_SCHK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_CUR;
      end
      S_CUR: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_scan ? S_SRD : S_DONE;
      end
      S_SRD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCHK;
      end
      S_SCHK: begin
        cmd.scan_chk = 1'b1;
        state_nxt    = (sts.hit || sts.exhausted) ? S_DONE : S_SRD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/eotd_dpath.sv
// Datapath: order table, merge logic, floor scan and output register.
// Depends on eotd_pkg; driven by eotd_ctrl commands.
module eotd_dpath #(
  parameter int FLOORS = eotd_pkg::FLOORS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_tdata,
  input  logic [1:0]          in_tuser,
  input  eotd_pkg::eotd_cmd_t cmd,
  output eotd_pkg::eotd_sts_t sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata
);

  localparam int IW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int XW = ((IW > 2) ? IW : 2) + 1;

  logic [1:0] mode_r, floor_r, dir_r;
  logic       bu_r, bd_r, bi_r;

  logic [2:0]        mem_r [FLOORS];
  logic [FLOORS-1:0] vld_r;
  logic [2:0]        rd_code_r;
  logic              rd_vld_r;

  logic [IW-1:0] idx_r;
  logic [1:0]    pass_r;

  logic [2:0] res_code_r;
  logic       res_lu_r, res_ld_r, res_li_r, res_dv_r;
  logic [1:0] res_dest_r;

  logic        out_tvalid_r;
  logic [15:0] out_tdata_r;

  logic [XW-1:0] fl_x, idx_x;
  logic          inrange;
  logic [IW-1:0] cur_idx, rd_addr;
  logic [2:0]    rd_c, merged;
  logic          up_dir, dir_match, hit, at_end;

  always_comb begin
    fl_x    = XW'(floor_r);
    idx_x   = XW'(idx_r);
    inrange = (fl_x < XW'(FLOORS));
    cur_idx = inrange ? IW'(fl_x) : IW'(FLOORS - 1);
    rd_addr = cmd.rd_scan ? idx_r : cur_idx;
    rd_c    = rd_vld_r ? rd_code_r : eotd_pkg::CODE_NONE;

    if ((rd_c == eotd_pkg::CODE_DOWN && bu_r) || (rd_c == eotd_pkg::CODE_UP && bd_r)) begin
      merged = eotd_pkg::CODE_BOTH;
    end else if (bu_r) begin
      merged = eotd_pkg::CODE_UP;
    end else if (bd_r) begin
      merged = eotd_pkg::CODE_DOWN;
    end else if (bi_r) begin
      merged = eotd_pkg::CODE_INSIDE;
    end else begin
      merged = rd_c;
    end

    up_dir    = (dir_r == eotd_pkg::DIR_UP) ^ (pass_r == eotd_pkg::PASS_BACK);
    dir_match = (rd_c == eotd_pkg::CODE_INSIDE) || (rd_c == eotd_pkg::CODE_BOTH) ||
                (dir_r == eotd_pkg::DIR_UP && rd_c == eotd_pkg::CODE_UP) ||
                (dir_r == eotd_pkg::DIR_DOWN && rd_c == eotd_pkg::CODE_DOWN);
    hit       = (rd_c != eotd_pkg::CODE_NONE) &&
                ((pass_r != eotd_pkg::PASS_MATCH) || dir_match);
    at_end    = up_dir ? (idx_r == IW'(FLOORS - 1)) : (idx_r == '0);

    sts.need_scan = (mode_r == eotd_pkg::MODE_QUERY) &&
                    (dir_r == eotd_pkg::DIR_UP || dir_r == eotd_pkg::DIR_DOWN);
    sts.hit       = hit;
    sts.exhausted = !hit && at_end && (pass_r == eotd_pkg::PASS_BACK);
    sts.out_free  = !out_tvalid_r || out_tready;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_tuser;
      floor_r <= in_tdata[1:0];
      bu_r    <= in_tdata[2];
      bd_r    <= in_tdata[3];
      bi_r    <= in_tdata[4];
      dir_r   <= in_tdata[6:5];
    end
  end

  // order table, one read port with registered data
  always_ff @(posedge clk) begin
    if (cmd.rd_cur || cmd.rd_scan) begin
      rd_code_r <= mem_r[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
    if (cmd.exec && mode_r == eotd_pkg::MODE_SAMPLE && inrange) begin
      mem_r[cur_idx] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.exec) begin
      case (mode_r)
        eotd_pkg::MODE_SAMPLE: begin
          if (inrange) vld_r[cur_idx] <= 1'b1;
        end
        eotd_pkg::MODE_CLR_FLOOR: begin
          if (inrange) vld_r[cur_idx] <= 1'b0;
        end
        eotd_pkg::MODE_CLR_ALL: begin
          vld_r <= '0;
        end
        default: begin
          vld_r <= vld_r;
        end
      endcase
    end
  end

  // result and scan position
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx_r      <= cur_idx;
      pass_r     <= eotd_pkg::PASS_MATCH;
      res_dest_r <= 2'd0;
      res_dv_r   <= 1'b0;
      if (mode_r == eotd_pkg::MODE_SAMPLE && inrange) begin
        res_code_r <= merged;
        res_lu_r   <= (merged == eotd_pkg::CODE_UP) || (merged == eotd_pkg::CODE_BOTH);
        res_ld_r   <= (merged == eotd_pkg::CODE_DOWN) || (merged == eotd_pkg::CODE_BOTH);
        res_li_r   <= (merged == eotd_pkg::CODE_INSIDE);
      end else begin
        res_code_r <= (mode_r == eotd_pkg::MODE_QUERY) ? rd_c : eotd_pkg::CODE_NONE;
        res_lu_r   <= 1'b0;
        res_ld_r   <= 1'b0;
        res_li_r   <= 1'b0;
      end
    end else if (cmd.scan_chk) begin
      if (hit) begin
        res_dest_r <= idx_x[1:0];
        res_dv_r   <= 1'b1;
      end else if (at_end) begin
        pass_r <= pass_r + 2'd1;
        idx_r  <= cur_idx;
      end else begin
        idx_r <= up_dir ? (idx_r + IW'(1)) : (idx_r - IW'(1));
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata_r <= {7'd0, res_dv_r, res_dest_r, res_li_r, res_ld_r, res_lu_r, res_code_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> sv/elevator_order_table_dispatch_core.sv
// Elevator order table dispatch core: top level joining sequencer and datapath.
// Sequence: a request is captured, its floor's table entry is read, then executed; a query
// with a direction then walks the table one floor per step through the single read port,
// alternating read and check, and the result waits until the output register is free.
// One request at a time: a new request is taken only once the last result has been loaded.
// Reset (rst_n low, synchronous): all floors read as no order, output empty.
module elevator_order_table_dispatch_core #(
  parameter int FLOORS = eotd_pkg::FLOORS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // floor[1:0], button_up, button_down, button_inside, direction[1:0]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // order_code[2:0], lamp_up, lamp_down, lamp_inside,
                                  // dest_floor[1:0], dest_valid
);

  eotd_pkg::eotd_cmd_t cmd;
  eotd_pkg::eotd_sts_t sts;

  eotd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eotd_dpath #(
    .FLOORS (FLOORS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for elevator_order_table_dispatch_core: merges, clears and destination
// queries are predicted from a local copy of the order table and checked per result field.
// Depends on eotd_pkg for order, mode, direction and pass codes.
module tb_top;

  localparam int FLOORS = eotd_pkg::FLOORS_DEF;
  localparam int RANDOM_REQS = 1550;
  localparam int CALM_TAIL = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] DIR_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0] mode;
    logic [1:0] floor;
    logic       up;
    logic       down;
    logic       cab;
    logic [1:0] dir;
    bit         drain;
  } order_req_t;

  typedef struct {
    logic [2:0] code;
    logic       lamp_up;
    logic       lamp_down;
    logic       lamp_inside;
    logic [1:0] dest;
    logic       dest_valid;
  } order_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // floor[1:0], button_up, button_down, button_inside, direction[1:0]
  logic [1:0]  in_tuser = '0;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // order_code[2:0], lamp_up, lamp_down, lamp_inside,
                                // dest_floor[1:0], dest_valid

  order_req_t  order_requests[$];
  order_resp_t expected_resps[$];
  logic [2:0]  floor_codes[FLOORS];
  order_req_t  cur_req;
  int          total_reqs;
  int          taken_cnt = 0;
  int          checked_cnt = 0;
  int          error_cnt = 0;
  int          sample_cnt = 0;
  int          query_cnt = 0;
  int          found_cnt = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  elevator_order_table_dispatch_core #(.FLOORS(FLOORS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic order_resp_t apply_order_request(order_req_t rq);
    order_resp_t r;
    logic [2:0]  c;
    int          cur;
    int          f;
    int          stride;
    bit          inrange;
    bit          dir_hit;
    r = '{default: '0};
    inrange = rq.floor < FLOORS;
    case (rq.mode)
      eotd_pkg::MODE_SAMPLE: begin
        sample_cnt++;
        if (inrange) begin
          c = floor_codes[rq.floor];
          if ((c == eotd_pkg::CODE_DOWN && rq.up) || (c == eotd_pkg::CODE_UP && rq.down))
            c = eotd_pkg::CODE_BOTH;
          else if (rq.up) c = eotd_pkg::CODE_UP;
          else if (rq.down) c = eotd_pkg::CODE_DOWN;
          else if (rq.cab) c = eotd_pkg::CODE_INSIDE;
          floor_codes[rq.floor] = c;
          r.code = c;
          r.lamp_up = (c == eotd_pkg::CODE_UP || c == eotd_pkg::CODE_BOTH);
          r.lamp_down = (c == eotd_pkg::CODE_DOWN || c == eotd_pkg::CODE_BOTH);
          r.lamp_inside = (c == eotd_pkg::CODE_INSIDE);
        end
      end
      eotd_pkg::MODE_CLR_FLOOR: begin
        if (inrange) floor_codes[rq.floor] = eotd_pkg::CODE_NONE;
      end
      eotd_pkg::MODE_CLR_ALL: begin
        for (int i = 0; i < FLOORS; i++) floor_codes[i] = eotd_pkg::CODE_NONE;
      end
      default: begin
        query_cnt++;
        cur = inrange ? int'(rq.floor) : FLOORS - 1;
        r.code = floor_codes[cur];
        if (rq.dir == eotd_pkg::DIR_UP || rq.dir == eotd_pkg::DIR_DOWN) begin
          // same direction with a match, same direction with any order, then reverse
          for (int p = eotd_pkg::PASS_MATCH; p <= eotd_pkg::PASS_BACK && !r.dest_valid; p++) begin
            stride = ((rq.dir == eotd_pkg::DIR_UP) ^ (p == eotd_pkg::PASS_BACK)) ? 1 : -1;
            f = cur;
            while (f >= 0 && f < FLOORS && !r.dest_valid) begin
              c = floor_codes[f];
              dir_hit = (c == eotd_pkg::CODE_INSIDE) || (c == eotd_pkg::CODE_BOTH) ||
                        (rq.dir == eotd_pkg::DIR_UP && c == eotd_pkg::CODE_UP) ||
                        (rq.dir == eotd_pkg::DIR_DOWN && c == eotd_pkg::CODE_DOWN);
              if (c != eotd_pkg::CODE_NONE && (p != eotd_pkg::PASS_MATCH || dir_hit)) begin
                r.dest_valid = 1'b1;
                r.dest = f[1:0];
              end
              f += stride;
            end
          end
        end
        if (r.dest_valid) found_cnt++;
      end
    endcase
    return r;
  endfunction

  task automatic add_request(logic [1:0] mode, logic [1:0] floor, logic up, logic down,
                             logic cab, logic [1:0] dir, bit drain);
    order_requests.push_back('{mode, floor, up, down, cab, dir, drain});
  endtask

  // request driver
  always @(posedge clk) begin : driver
    bit         present;
    order_req_t nxt;
    present = in_tvalid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_resps.push_back(apply_order_request(cur_req));
        taken_cnt++;
        present = 1'b0;
        if (taken_cnt >= total_reqs - CALM_TAIL) calm = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 12);
      end
      if (!present) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (order_requests.size() > 0 &&
                     !(order_requests[0].drain && expected_resps.size() != 0)) begin
          nxt = order_requests.pop_front();
          cur_req = nxt;
          in_tvalid <= 1'b1;
          in_tdata <= {1'b0, nxt.dir, nxt.cab, nxt.down, nxt.up, nxt.floor};
          in_tuser <= nxt.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    order_resp_t got;
    order_resp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.code = out_tdata[2:0];
        got.lamp_up = out_tdata[3];
        got.lamp_down = out_tdata[4];
        got.lamp_inside = out_tdata[5];
        got.dest = out_tdata[7:6];
        got.dest_valid = out_tdata[8];
        checked_cnt++;
        if (expected_resps.size() == 0) begin
          $error("unexpected result 0x%04h", out_tdata);
          error_cnt++;
        end else begin
          want = expected_resps.pop_front();
          if (got.code !== want.code) begin
            $error("order_code: expected %0d, got %0d", want.code, got.code);
            error_cnt++;
          end
          if (got.lamp_up !== want.lamp_up) begin
            $error("lamp_up: expected %0d, got %0d", want.lamp_up, got.lamp_up);
            error_cnt++;
          end
          if (got.lamp_down !== want.lamp_down) begin
            $error("lamp_down: expected %0d, got %0d", want.lamp_down, got.lamp_down);
            error_cnt++;
          end
          if (got.lamp_inside !== want.lamp_inside) begin
            $error("lamp_inside: expected %0d, got %0d", want.lamp_inside, got.lamp_inside);
            error_cnt++;
          end
          if (got.dest !== want.dest) begin
            $error("dest_floor: expected %0d, got %0d", want.dest, got.dest);
            error_cnt++;
          end
          if (got.dest_valid !== want.dest_valid) begin
            $error("dest_valid: expected %0d, got %0d", want.dest_valid, got.dest_valid);
            error_cnt++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(1, 12) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int         r;
    logic [1:0] mode;
    logic [1:0] dir;
    for (int i = 0; i < FLOORS; i++) floor_codes[i] = eotd_pkg::CODE_NONE;

    // directed: empty table, merge rules, lamps, scan passes, stopped/unknown direction, clears
    add_request(eotd_pkg::MODE_QUERY,     2'd0, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_UP,   1'b0);
    add_request(eotd_pkg::MODE_QUERY,     2'd3, 1'b1, 1'b1, 1'b1, eotd_pkg::DIR_DOWN, 1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd0, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_STOP, 1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd0, 1'b0, 1'b1, 1'b0, eotd_pkg::DIR_STOP, 1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd0, 1'b1, 1'b0, 1'b0, eotd_pkg::DIR_STOP, 1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd0, 1'b1, 1'b0, 1'b0, eotd_pkg::DIR_STOP, 1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd0, 1'b0, 1'b1, 1'b0, eotd_pkg::DIR_STOP, 1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd3, 1'b0, 1'b0, 1'b1, DIR_UNKNOWN,        1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd3, 1'b1, 1'b1, 1'b1, DIR_UNKNOWN,        1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd1, 1'b0, 1'b0, 1'b1, eotd_pkg::DIR_UP,   1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd1, 1'b0, 1'b1, 1'b0, eotd_pkg::DIR_DOWN, 1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd2, 1'b1, 1'b1, 1'b0, eotd_pkg::DIR_UP,   1'b0);
    add_request(eotd_pkg::MODE_QUERY,     2'd1, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_UP,   1'b0);
    add_request(eotd_pkg::MODE_QUERY,     2'd1, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_DOWN, 1'b0);
    add_request(eotd_pkg::MODE_QUERY,     2'd2, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_STOP, 1'b0);
    add_request(eotd_pkg::MODE_QUERY,     2'd3, 1'b0, 1'b0, 1'b0, DIR_UNKNOWN,        1'b0);
    add_request(eotd_pkg::MODE_QUERY,     2'd0, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_DOWN, 1'b0);
    add_request(eotd_pkg::MODE_CLR_FLOOR, 2'd0, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_STOP, 1'b0);
    add_request(eotd_pkg::MODE_CLR_FLOOR, 2'd3, 1'b1, 1'b1, 1'b1, DIR_UNKNOWN,        1'b0);
    add_request(eotd_pkg::MODE_QUERY,     2'd3, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_UP,   1'b0);
    add_request(eotd_pkg::MODE_QUERY,     2'd0, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_UP,   1'b0);
    add_request(eotd_pkg::MODE_CLR_ALL,   2'd2, 1'b1, 1'b0, 1'b1, eotd_pkg::DIR_DOWN, 1'b0);
    add_request(eotd_pkg::MODE_QUERY,     2'd2, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_DOWN, 1'b0);
    add_request(eotd_pkg::MODE_SAMPLE,    2'd3, 1'b0, 1'b0, 1'b1, eotd_pkg::DIR_STOP, 1'b0);
    add_request(eotd_pkg::MODE_QUERY,     2'd0, 1'b0, 1'b0, 1'b0, eotd_pkg::DIR_UP,   1'b1);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) mode = eotd_pkg::MODE_SAMPLE;
      else if (r < 55) mode = eotd_pkg::MODE_CLR_FLOOR;
      else if (r < 58) mode = eotd_pkg::MODE_CLR_ALL;
      else mode = eotd_pkg::MODE_QUERY;
      r = $urandom_range(0, 99);
      if (r < 8) dir = eotd_pkg::DIR_STOP;
      else if (r < 13) dir = DIR_UNKNOWN;
      else if (r < 56) dir = eotd_pkg::DIR_UP;
      else dir = eotd_pkg::DIR_DOWN;
      add_request(mode, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), dir,
                  (i % 400) == 200);
    end
    total_reqs = order_requests.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (taken_cnt < total_reqs) @(posedge clk);
    while (expected_resps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("tb_top: %0d requests, %0d results checked, %0d errors", total_reqs, checked_cnt,
             error_cnt);
    $display("tb_top: %0d button samples, %0d queries (%0d with a destination)", sample_cnt,
             query_cnt, found_cnt);
    if (error_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> elevator_order_table_dispatch_core.f
sv/eotd_pkg.sv
sv/eotd_ctrl.sv
sv/eotd_dpath.sv
sv/elevator_order_table_dispatch_core.sv
tb/sv/tb_top.sv
